>>> rtl/core/five_tuple_rule_classifier_macros.svh
// assertion macros for the five-tuple rule classifier
`ifndef FIVE_TUPLE_RULE_CLASSIFIER_MACROS_SVH
`define FIVE_TUPLE_RULE_CLASSIFIER_MACROS_SVH

// condition implies expression in the same cycle
`define FTRC_ASSERT_SAME(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// condition implies expression in the next cycle
`define FTRC_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

>>> rtl/core/ftrc_pkg.sv
// shared types and constants for the five-tuple rule classifier
package ftrc_pkg;

	localparam int unsigned MAX_RULES_DEF = 64;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_MATCH = 1'b1;

	typedef struct packed {
		logic [31:0] proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_lo;
		logic [15:0] src_hi;
		logic [15:0] dst_lo;
		logic [15:0] dst_hi;
	} rule_t;

	typedef struct packed {
		logic        proto_any;
		logic [31:0] proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} key_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

endpackage

>>> rtl/core/ftrc_rule_mem.sv
// rule table memory, one write port and one registered read port
module ftrc_rule_mem #(
	parameter int unsigned DEPTH = ftrc_pkg::MAX_RULES_DEF,
	parameter int unsigned IW    = 6
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  ftrc_pkg::rule_t wr_data,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_addr,
	output ftrc_pkg::rule_t rd_data
);
	import ftrc_pkg::*;

	rule_t mem [DEPTH];
	rule_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/ftrc_match_unit.sv
// compares one stored rule against the packet key
module ftrc_match_unit (
	input  ftrc_pkg::rule_t rule,
	input  ftrc_pkg::key_t  key,
	output logic            rule_hit
);
	import ftrc_pkg::*;

	logic proto_ok;
	logic src_addr_ok;
	logic dst_addr_ok;
	logic src_port_ok;
	logic dst_port_ok;

	always_comb begin
		proto_ok    = key.proto_any || (rule.proto == key.proto);
		src_addr_ok = (rule.src_addr == '0) || (rule.src_addr == key.src_addr);
		dst_addr_ok = (rule.dst_addr == '0) || (rule.dst_addr == key.dst_addr);
		// a range with a zero bound is open
		src_port_ok = (rule.src_lo == '0) || (rule.src_hi == '0) ||
			((key.src_port >= rule.src_lo) && (key.src_port <= rule.src_hi));
		dst_port_ok = (rule.dst_lo == '0) || (rule.dst_hi == '0) ||
			((key.dst_port >= rule.dst_lo) && (key.dst_port <= rule.dst_hi));
		rule_hit = proto_ok && src_addr_ok && dst_addr_ok && src_port_ok && dst_port_ok;
	end

endmodule

>>> rtl/core/five_tuple_rule_classifier.sv
// First-match five-tuple classifier. One transaction is taken at a time; in_ready is high
// only while the block is idle. An add writes the rule into the next free slot at the
// accept edge, and its result is loaded from ST_FIN into the output registers; a full
// table refuses the add. A match walks the stored rules newest first through the single
// read port of the rule memory, one rule per cycle, with one shared compare unit, and
// stops early at the first hit; an empty table goes straight to ST_FIN, as for an add.
// The rule memory needs no clearing after reset: only slots that were written are ever
// scanned.
`include "five_tuple_rule_classifier_macros.svh"

module five_tuple_rule_classifier #(
	parameter int unsigned MAX_RULES = ftrc_pkg::MAX_RULES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] proto_code,
	input  logic        proto_any,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] src_port_top,
	input  logic [15:0] dst_port,
	input  logic [15:0] dst_port_top,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [5:0]  hit_slot,
	output logic [6:0]  rules_held,
	output logic        add_refused
);
	import ftrc_pkg::*;

	localparam int unsigned IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int unsigned CW = $clog2(MAX_RULES + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic [IW-1:0] ptr_q;
	logic          valid_s1;
	logic [IW-1:0] slot_s1;
	key_t          key_q;
	logic          res_hit_q;
	logic [IW-1:0] res_slot_q;
	logic          res_refused_q;
	logic          out_valid_q;
	logic          hit_q;
	logic [5:0]    slot_q;
	logic [6:0]    held_q;
	logic          refused_q;

	logic          in_accept;
	logic          full;
	logic          out_free;
	logic          wr_en;
	logic          rd_en;
	logic          load_out;
	logic          rule_hit;
	logic          scan_hit;
	rule_t         wr_rule;
	rule_t         rd_rule;

	assign in_accept = in_valid && in_ready;
	assign full      = (count_q == CW'(MAX_RULES));
	assign out_free  = !out_valid_q || out_ready;
	assign scan_hit  = valid_s1 && rule_hit;

	always_comb begin
		wr_rule.proto    = proto_code;
		wr_rule.src_addr = src_addr;
		wr_rule.dst_addr = dst_addr;
		wr_rule.src_lo   = src_port;
		wr_rule.src_hi   = src_port_top;
		wr_rule.dst_lo   = dst_port;
		wr_rule.dst_hi   = dst_port_top;
	end

	ftrc_rule_mem #(
		.DEPTH (MAX_RULES),
		.IW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (wr_rule),
		.rd_en   (rd_en),
		.rd_addr (ptr_q),
		.rd_data (rd_rule)
	);

	ftrc_match_unit u_match (
		.rule     (rd_rule),
		.key      (key_q),
		.rule_hit (rule_hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (kind == KIND_MATCH && count_q != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					state_d = ST_FIN;
				end else if (ptr_q == '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		rd_en    = (state_q == ST_SCAN);
		wr_en    = in_accept && (kind == KIND_ADD) && !full;
		load_out = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= ptr_q;
		if (in_accept) begin
			key_q.proto_any <= proto_any;
			key_q.proto     <= proto_code;
			key_q.src_addr  <= src_addr;
			key_q.dst_addr  <= dst_addr;
			key_q.src_port  <= src_port;
			key_q.dst_port  <= dst_port;
			ptr_q           <= IW'(count_q - CW'(1));
			res_hit_q       <= 1'b0;
			res_slot_q      <= '0;
			res_refused_q   <= (kind == KIND_ADD) && full;
		end else begin
			if (rd_en && ptr_q != '0) begin
				ptr_q <= ptr_q - IW'(1);
			end
			// first hit in newest-first order wins, the scan stops there
			if ((state_q == ST_SCAN || state_q == ST_DRAIN) && scan_hit) begin
				res_hit_q  <= 1'b1;
				res_slot_q <= slot_s1;
			end
		end
		if (load_out) begin
			hit_q     <= res_hit_q;
			slot_q    <= 6'(res_slot_q);
			held_q    <= 7'(count_q);
			refused_q <= res_refused_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign hit_slot    = slot_q;
	assign rules_held  = held_q;
	assign add_refused = refused_q;

	`FTRC_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(MAX_RULES), "rule count past table size")
	`FTRC_ASSERT_NEXT(a_count_inc, wr_en, count_q == $past(count_q) + CW'(1), "add did not count")
	`FTRC_ASSERT_SAME(a_hit_slot, res_hit_q, CW'(res_slot_q) < count_q, "hit on unwritten slot")
	`FTRC_ASSERT_SAME(a_drain_valid, state_q == ST_DRAIN, valid_s1, "drain without pending read")

endmodule
